// File: sv/bmsb_pkg.sv
package bmsb_pkg;

    // Cycle type codes
    localparam logic [2:0] CT_INCR = 3'b010;
    localparam logic [2:0] CT_END  = 3'b111;

    // Burst type code for a linear burst; other codes wrap over 4, 8 or 16 beats
    localparam logic [1:0] BT_LINEAR = 2'b00;

    // Beat direction
    localparam logic FUNC_WRITE = 1'b1;

    // Read data returned by a read outside the window
    localparam logic [63:0] OOR_PATTERN = 64'h0000_0000_EEEE_EEEE;

    typedef struct packed {
        logic        func;
        logic [31:0] addr;
        logic [7:0]  byte_select;
        logic [63:0] write_data;
        logic [2:0]  cycle_type;
        logic [1:0]  burst_type;
    } req_t;

    typedef struct packed {
        logic [63:0] read_data;
        logic        ack;
        logic        out_of_range;
    } rsp_t;

    // Controller to datapath commands
    typedef struct packed {
        logic clear;
        logic capture;
        logic exec;
        logic merge;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic clear_last;
    } stat_t;

    // Advance a burst address by one bus word, linearly or wrapping
    function automatic logic [31:0] advance(input logic [31:0] a,
                                            input logic [1:0]  bt,
                                            input logic [1:0]  lane_log2);
        logic [31:0] step;
        logic [31:0] mask;
        logic [31:0] sum;
        step = 32'd1 << lane_log2;
        sum  = a + step;
        mask = (step << ({1'b0, bt} + 3'd1)) - 32'd1;
        if (bt == BT_LINEAR)
        begin
            return sum;
        end
        return (a & ~mask) | (sum & mask);
    endfunction

endpackage

// File: sv/bmsb_ctrl.sv
module bmsb_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  bmsb_pkg::stat_t  stat,
    output bmsb_pkg::cmd_t   cmd,
    output logic             busy,
    output logic             done
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;
    localparam logic [1:0] S_MERGE = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       done_reg;

    // Sequence clearing pass, then one request at a time
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:  state_next = S_MERGE;
            S_MERGE: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_MERGE);
        end
    end

    // Drive commands from the current state
    always_comb
    begin
        cmd.clear   = (state_reg == S_CLEAR);
        cmd.capture = (state_reg == S_IDLE) && start;
        cmd.exec    = (state_reg == S_EXEC);
        cmd.merge   = (state_reg == S_MERGE);
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule

// File: sv/bmsb_datapath.sv
module bmsb_datapath
#(
    parameter int BUS_WIDTH = 64,
    parameter int MEM_WORDS = 4096
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  bmsb_pkg::cmd_t   cmd,
    output bmsb_pkg::stat_t  stat,
    input  bmsb_pkg::req_t   request,
    input  logic             cfg_write,
    input  logic [31:0]      cfg_data,
    output bmsb_pkg::rsp_t   result
);

    localparam int          LANE_LOG2 = (BUS_WIDTH >= 64) ? 3 : 2;
    localparam int          LANES     = 1 << LANE_LOG2;
    localparam int          DW        = LANES * 8;
    localparam int          AW        = $clog2(MEM_WORDS);
    localparam int unsigned WINDOW    = MEM_WORDS * LANES;

    logic [DW-1:0]  mem [MEM_WORDS];

    bmsb_pkg::req_t req_reg;
    logic [31:0]    base_reg;
    logic           in_burst_reg;
    logic [31:0]    burst_addr_reg;
    logic [63:0]    last_read_reg;
    logic [63:0]    last_read_next;
    logic [DW-1:0]  rd_data_reg;
    logic           oor_reg;
    logic [AW-1:0]  clr_cnt_reg;
    bmsb_pkg::rsp_t result_reg;

    logic [31:0]    beat_addr;
    logic [31:0]    offset;
    logic           oor;
    logic [AW-1:0]  word_idx;
    logic [63:0]    merged;

    // Window register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
        end
        else if (cfg_write)
        begin
            base_reg <= cfg_data;
        end
    end

    // Hold the request while it is worked on
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= request;
        end
    end

    // Clearing pass counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clear)
        begin
            clr_cnt_reg <= clr_cnt_reg + AW'(1);
        end
    end

    assign stat.clear_last = (clr_cnt_reg == AW'(MEM_WORDS - 1));

    // Beat address and window test
    assign beat_addr = in_burst_reg ? burst_addr_reg : req_reg.addr;
    assign offset    = beat_addr - base_reg;
    assign oor       = (offset >= 32'(WINDOW));
    assign word_idx  = offset[LANE_LOG2 +: AW];

    // Memory: one write port shared by the clearing pass, one registered read
    always_ff @(posedge clk)
    begin
        if (cmd.clear)
        begin
            mem[clr_cnt_reg] <= '0;
        end
        else if (cmd.exec && !oor && req_reg.func == bmsb_pkg::FUNC_WRITE)
        begin
            for (int n = 0; n < LANES; n++)
            begin
                if (req_reg.byte_select[n])
                begin
                    mem[word_idx][8*n +: 8] <= req_reg.write_data[8*n +: 8];
                end
            end
        end
        if (cmd.exec)
        begin
            rd_data_reg <= mem[word_idx];
        end
    end

    // Advance or close the burst after each beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_burst_reg   <= 1'b0;
            burst_addr_reg <= '0;
            oor_reg        <= 1'b0;
        end
        else if (cmd.exec)
        begin
            oor_reg <= oor;
            if (in_burst_reg)
            begin
                burst_addr_reg <= bmsb_pkg::advance(burst_addr_reg, req_reg.burst_type,
                                                    2'(LANE_LOG2));
                if (req_reg.cycle_type == bmsb_pkg::CT_END)
                begin
                    in_burst_reg <= 1'b0;
                end
            end
            else if (req_reg.cycle_type == bmsb_pkg::CT_INCR)
            begin
                burst_addr_reg <= bmsb_pkg::advance(req_reg.addr, req_reg.burst_type,
                                                    2'(LANE_LOG2));
                in_burst_reg   <= 1'b1;
            end
        end
    end

    // Drop disabled lanes from the read word
    always_comb
    begin
        merged = '0;
        for (int n = 0; n < LANES; n++)
        begin
            if (req_reg.byte_select[n])
            begin
                merged[8*n +: 8] = rd_data_reg[8*n +: 8];
            end
        end
    end

    always_comb
    begin
        last_read_next = last_read_reg;
        if (req_reg.func != bmsb_pkg::FUNC_WRITE)
        begin
            last_read_next = oor_reg ? bmsb_pkg::OOR_PATTERN : merged;
        end
    end

    // Register the response
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_read_reg <= '0;
        end
        else if (cmd.merge)
        begin
            last_read_reg <= last_read_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.merge)
        begin
            result_reg.read_data    <= last_read_next;
            result_reg.ack          <= 1'b1;
            result_reg.out_of_range <= oor_reg;
        end
    end

    assign result = result_reg;

endmodule

// File: sv/bus_memory_slave_burst.sv
// Bus memory slave with incrementing and wrapping bursts.
// Request channel: present a beat on request and raise start; the beat is
// taken at a rising edge where start is high and busy is low.
// Response channel: done pulses for one cycle with result valid alongside;
// the receiver cannot hold it off, so it must sample result on that cycle.
// Configuration: cfg_write with cfg_data loads the window base address;
// write it only while no request is outstanding.
// Timing: a taken request is executed in state S_EXEC (address
// subtract, window compare and memory access), its read lanes are merged in
// S_MERGE, and done is registered from S_MERGE. busy falls as done
// rises, so a new request is taken only after the last one is done; the
// controller FSM and the registered memory read sit in that path.
// Reset: rst_n is asynchronous. After reset a clearing pass writes zero to
// every memory word, one word a cycle; busy stays high during it. Burst
// state, last read data and the base address reset to zero.
module bus_memory_slave_burst
#(
    parameter int BUS_WIDTH = 64,
    parameter int MEM_WORDS = 4096
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  bmsb_pkg::req_t  request,
    output logic            done,
    output bmsb_pkg::rsp_t  result,
    input  logic            cfg_write,
    input  logic [31:0]     cfg_data
);

    bmsb_pkg::cmd_t  cmd;
    bmsb_pkg::stat_t stat;

    bmsb_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    bmsb_datapath
    #(
        .BUS_WIDTH (BUS_WIDTH),
        .MEM_WORDS (MEM_WORDS)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .request   (request),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .result    (result)
    );

endmodule

// File: test/bus_memory_slave_burst_check.sv
`timescale 1ns / 100ps

module bus_memory_slave_burst_check
#(
    parameter int MEM_WORDS = 4096
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic            busy,
    input  bmsb_pkg::req_t  request,
    input  logic            done,
    input  bmsb_pkg::rsp_t  result,
    input  logic            cfg_write,
    input  logic [31:0]     cfg_data,
    output int              mismatches,
    output int              outstanding
);

    localparam int          LANES        = 8;
    localparam logic [31:0] WINDOW_BYTES = 32'(MEM_WORDS * LANES);
    localparam int          REPORT_LIMIT = 10;

    logic [63:0]    mem_image [MEM_WORDS];
    logic           in_burst;
    logic [31:0]    burst_addr;
    logic [63:0]    last_read;
    logic [31:0]    window_base;
    bmsb_pkg::rsp_t awaited_rsp [$];
    int             fail_count;

    // Step a burst address by one bus word, wrapping inside the block when asked
    function automatic logic [31:0] next_burst_addr(input logic [31:0] a,
                                                    input logic [1:0]  bt);
        logic [31:0] span;
        if (bt == bmsb_pkg::BT_LINEAR)
        begin
            return a + 32'd8;
        end
        span = (32'd8 << (int'(bt) + 1)) - 32'd1;
        return (a & ~span) | ((a + 32'd8) & span);
    endfunction

    // Perform one beat on the memory image; return the out-of-range flag
    function automatic logic access_window(input bmsb_pkg::req_t r, input logic [31:0] a);
        logic [31:0] offset;
        logic [63:0] lanes;
        int          word;
        int          n;
        offset = a - window_base;
        if (offset >= WINDOW_BYTES)
        begin
            if (r.func != bmsb_pkg::FUNC_WRITE)
            begin
                last_read = bmsb_pkg::OOR_PATTERN;
            end
            return 1'b1;
        end
        word  = int'(offset >> 3);
        lanes = '0;
        for (n = 0; n < LANES; n++)
        begin
            if (r.byte_select[n])
            begin
                if (r.func == bmsb_pkg::FUNC_WRITE)
                begin
                    mem_image[word][8*n +: 8] = r.write_data[8*n +: 8];
                end
                else
                begin
                    lanes[8*n +: 8] = mem_image[word][8*n +: 8];
                end
            end
        end
        if (r.func != bmsb_pkg::FUNC_WRITE)
        begin
            last_read = lanes;
        end
        return 1'b0;
    endfunction

    // Work out the response to one request and advance the burst state
    function automatic bmsb_pkg::rsp_t predict_rsp(input bmsb_pkg::req_t r);
        bmsb_pkg::rsp_t rsp;
        logic           oor;
        if (in_burst)
        begin
            oor        = access_window(r, burst_addr);
            burst_addr = next_burst_addr(burst_addr, r.burst_type);
            if (r.cycle_type == bmsb_pkg::CT_END)
            begin
                in_burst = 1'b0;
            end
        end
        else if (r.cycle_type == bmsb_pkg::CT_INCR)
        begin
            oor        = access_window(r, r.addr);
            burst_addr = next_burst_addr(r.addr, r.burst_type);
            in_burst   = 1'b1;
        end
        else
        begin
            oor = access_window(r, r.addr);
        end
        rsp.read_data    = last_read;
        rsp.ack          = 1'b1;
        rsp.out_of_range = oor;
        return rsp;
    endfunction

    // Track configuration, compare responses, queue predictions
    always @(posedge clk or negedge rst_n)
    begin
        bmsb_pkg::rsp_t want;
        if (!rst_n)
        begin
            foreach (mem_image[i])
            begin
                mem_image[i] = '0;
            end
            in_burst    = 1'b0;
            burst_addr  = '0;
            last_read   = '0;
            window_base = '0;
            fail_count  = 0;
            awaited_rsp.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_write)
            begin
                window_base = cfg_data;
            end
            if (done)
            begin
                if (awaited_rsp.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                    begin
                        $display("%0t: response with no request waiting:",
                                 $realtime, " data %h ack %b oor %b",
                                 result.read_data, result.ack, result.out_of_range);
                    end
                end
                else
                begin
                    want = awaited_rsp.pop_front();
                    if (result.read_data !== want.read_data || result.ack !== want.ack
                        || result.out_of_range !== want.out_of_range)
                    begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                        begin
                            $display("%0t: response mismatch:", $realtime,
                                     " expected data %h ack %b oor %b,",
                                     want.read_data, want.ack, want.out_of_range,
                                     " got data %h ack %b oor %b",
                                     result.read_data, result.ack, result.out_of_range);
                        end
                    end
                end
            end
            if (start && !busy)
            begin
                awaited_rsp.insert(awaited_rsp.size(), predict_rsp(request));
            end
            mismatches  <= fail_count;
            outstanding <= awaited_rsp.size();
        end
    end

endmodule

// File: test/bus_memory_slave_burst_test.sv
`timescale 1ns / 100ps

module bus_memory_slave_burst_test;

    localparam int          MEM_WORDS     = 4096;
    localparam int          WINDOW_BYTES  = MEM_WORDS * 8;
    localparam int          RANDOM_ITEMS  = 1830;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          STALL_LIMIT   = 20000;
    localparam logic [2:0]  CT_CLASSIC    = 3'b000;
    localparam logic [2:0]  CT_UNUSED     = 3'b001;
    localparam logic [1:0]  BT_WRAP4      = 2'b01;
    localparam logic [1:0]  BT_WRAP8      = 2'b10;
    localparam logic [1:0]  BT_WRAP16     = 2'b11;
    localparam logic        FUNC_READ     = 1'b0;
    localparam int          MODE_READ     = 0;
    localparam int          MODE_WRITE    = 1;
    localparam int          MODE_MIXED    = 2;

    logic           clk;
    logic           rst_n;
    logic           start;
    logic           busy;
    bmsb_pkg::req_t request;
    logic           done;
    bmsb_pkg::rsp_t result;
    logic           cfg_write;
    logic [31:0]    cfg_data;
    int             mismatches;
    int             outstanding;
    int             stall_cycles;
    int             idle_pct;
    int             sent;
    logic [31:0]    cur_base;
    logic [31:0]    base_plan [4];

    bus_memory_slave_burst
    #(
        .BUS_WIDTH (64),
        .MEM_WORDS (MEM_WORDS)
    )
    i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data)
    );

    bus_memory_slave_burst_check
    #(
        .MEM_WORDS (MEM_WORDS)
    )
    i_check
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .request     (request),
        .done        (done),
        .result      (result),
        .cfg_write   (cfg_write),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    // Abort when nothing moves for too long
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("bus_memory_slave_burst regression: fail");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic bmsb_pkg::req_t make_req(input logic        func,
                                                input logic [31:0] addr,
                                                input logic [7:0]  sel,
                                                input logic [63:0] wdata,
                                                input logic [2:0]  ct,
                                                input logic [1:0]  bt);
        bmsb_pkg::req_t r;
        r.func        = func;
        r.addr        = addr;
        r.byte_select = sel;
        r.write_data  = wdata;
        r.cycle_type  = ct;
        r.burst_type  = bt;
        return r;
    endfunction

    function automatic logic [63:0] rand_data();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [7:0] rand_sel();
        return ($urandom_range(99) < 30) ? 8'hFF : 8'($urandom());
    endfunction

    function automatic logic rand_func(input int mode);
        if (mode == MODE_MIXED)
        begin
            return 1'($urandom());
        end
        return (mode == MODE_WRITE) ? bmsb_pkg::FUNC_WRITE : FUNC_READ;
    endfunction

    // Favour a few busy words so that reads meet earlier writes
    function automatic logic [31:0] pick_addr();
        int roll;
        roll = $urandom_range(99);
        if (roll < 45)
        begin
            return cur_base + 32'($urandom_range(0, 31) * 8);
        end
        if (roll < 60)
        begin
            return cur_base + 32'(WINDOW_BYTES - 8 * $urandom_range(1, 16));
        end
        if (roll < 78)
        begin
            return cur_base + 32'($urandom_range(0, WINDOW_BYTES - 1));
        end
        if (roll < 84)
        begin
            return cur_base + 32'(WINDOW_BYTES + $urandom_range(0, 63));
        end
        if (roll < 90)
        begin
            return cur_base - 32'($urandom_range(1, 64));
        end
        return $urandom();
    endfunction

    // Present one request and hold it until taken; then maybe idle a while
    task automatic issue(input bmsb_pkg::req_t r);
        request <= r;
        start   <= 1'b1;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        sent++;
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // Stop sending and wait until every response is back
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_base(input logic [31:0] value);
        drain();
        while (busy)
        begin
            @(posedge clk);
        end
        cfg_write <= 1'b1;
        cfg_data  <= value;
        cur_base  = value;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // One burst: opening beat, continuation beats, closing beat
    task automatic send_burst(input logic [31:0] first_addr,
                              input logic [1:0]  bt,
                              input int          beats,
                              input int          mode,
                              input bit          noisy);
        logic [2:0] ct;
        logic [1:0] beat_bt;
        int         k;
        issue(make_req(rand_func(mode), first_addr, rand_sel(), rand_data(),
                       bmsb_pkg::CT_INCR, bt));
        for (k = 1; k < beats; k++)
        begin
            ct      = bmsb_pkg::CT_INCR;
            beat_bt = bt;
            if (k == beats - 1)
            begin
                ct = bmsb_pkg::CT_END;
            end
            else if (noisy && $urandom_range(99) < 20)
            begin
                ct = 3'($urandom_range(0, 6));
            end
            if (noisy && $urandom_range(99) < 10)
            begin
                beat_bt = 2'($urandom());
            end
            issue(make_req(rand_func(mode), noisy ? $urandom() : first_addr, rand_sel(),
                           rand_data(), ct, beat_bt));
        end
    endtask

    initial
    begin
        logic [2:0] ct;
        int         phase;
        int         per_phase;
        rst_n        <= 1'b0;
        start        <= 1'b0;
        request      <= '0;
        cfg_write    <= 1'b0;
        cfg_data     <= '0;
        stall_cycles <= 0;
        idle_pct     = 0;
        sent         = 0;
        cur_base     = '0;
        base_plan[0] = 32'h0000_0000;
        base_plan[1] = 32'hFFFF_C000;
        base_plan[2] = 32'hFFFF_FFFF;
        base_plan[3] = 32'h8000_0004;

        // Hold reset, then release at a clock edge
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: lane extremes, window edges, out-of-range, bursts of each kind
        write_base(32'h0000_0000);
        issue(make_req(bmsb_pkg::FUNC_WRITE, 32'h0, 8'hFF, '1, CT_CLASSIC,
                       bmsb_pkg::BT_LINEAR));
        issue(make_req(FUNC_READ, 32'h0, 8'hFF, '0, CT_CLASSIC, bmsb_pkg::BT_LINEAR));
        issue(make_req(FUNC_READ, 32'h0, 8'h00, '1, CT_CLASSIC, bmsb_pkg::BT_LINEAR));
        issue(make_req(FUNC_READ, 32'h0, 8'h01, '0, CT_UNUSED, BT_WRAP16));
        issue(make_req(bmsb_pkg::FUNC_WRITE, 32'h7FF8, 8'h80, rand_data(), CT_CLASSIC,
                       bmsb_pkg::BT_LINEAR));
        issue(make_req(FUNC_READ, 32'h7FFF, 8'hFF, '0, CT_CLASSIC, bmsb_pkg::BT_LINEAR));
        issue(make_req(FUNC_READ, 32'h8000, 8'hFF, '0, CT_CLASSIC, bmsb_pkg::BT_LINEAR));
        issue(make_req(bmsb_pkg::FUNC_WRITE, 32'h8000, 8'hFF, '1, CT_CLASSIC,
                       bmsb_pkg::BT_LINEAR));
        issue(make_req(FUNC_READ, 32'hFFFF_FFFF, 8'hFF, '0, bmsb_pkg::CT_END, BT_WRAP8));
        issue(make_req(bmsb_pkg::FUNC_WRITE, 32'h0, 8'h0F, '0, bmsb_pkg::CT_END,
                       bmsb_pkg::BT_LINEAR));
        send_burst(32'h10, BT_WRAP4, 4, MODE_WRITE, 1'b0);
        send_burst(32'h0, BT_WRAP4, 4, MODE_READ, 1'b0);
        send_burst(32'h7FF0, bmsb_pkg::BT_LINEAR, 4, MODE_READ, 1'b0);
        send_burst(32'h38, BT_WRAP16, 3, MODE_MIXED, 1'b0);
        send_burst(32'h18, BT_WRAP8, 2, MODE_READ, 1'b0);

        // Random: sweep the window base; sender idles 13%, then 45%, then not at all
        per_phase = RANDOM_ITEMS / 4;
        sent      = 0;
        for (phase = 0; phase < 4; phase++)
        begin
            write_base(base_plan[phase]);
            while (sent < per_phase * (phase + 1))
            begin
                if (sent < RANDOM_ITEMS / 3)
                begin
                    idle_pct = 13;
                end
                else if (sent < 2 * RANDOM_ITEMS / 3)
                begin
                    idle_pct = 45;
                end
                else
                begin
                    idle_pct = 0;
                end
                if ($urandom_range(99) < 55)
                begin
                    send_burst(pick_addr(), 2'($urandom()), $urandom_range(2, 18),
                               MODE_MIXED, $urandom_range(99) < 30);
                end
                else
                begin
                    ct = 3'($urandom());
                    if (ct == bmsb_pkg::CT_INCR && $urandom_range(99) < 90)
                    begin
                        ct = CT_CLASSIC;
                    end
                    issue(make_req(1'($urandom()), pick_addr(), rand_sel(), rand_data(),
                                   ct, 2'($urandom())));
                end
                // Let the pipeline run dry now and then
                if ($urandom_range(99) < 2)
                begin
                    drain();
                end
            end
        end

        // Close any burst left open by noise, then collect the last responses
        issue(make_req(FUNC_READ, cur_base, 8'hFF, '0, bmsb_pkg::CT_END,
                       bmsb_pkg::BT_LINEAR));
        drain();
        if (mismatches == 0)
        begin
            $display("bus_memory_slave_burst regression: pass");
        end
        else
        begin
            $display("bus_memory_slave_burst regression: fail");
        end
        $finish;
    end

endmodule
